@@ rtl/dlpg_pkg.sv @@
// Shared types, constants and control codes for the DDA line pixel generator.
package dlpg_pkg;

   localparam int COORD_W = 12;
   localparam int PIXEL_W = 6;
   localparam int EXTENT_W = 7;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W = EXTENT_W;

   localparam logic [EXTENT_W-1:0] MAX_WIDTH = 7'd64;
   localparam logic [EXTENT_W-1:0] MAX_HEIGHT = 7'd64;
   localparam logic [EXTENT_W-1:0] EXTENT_RESET = 7'd64;

   localparam logic [CSR_INDEX_W-1:0] CSR_ACTIVE_WIDTH = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACTIVE_HEIGHT = 1'b1;

   typedef struct packed {
      logic signed [COORD_W-1:0] start_x;
      logic signed [COORD_W-1:0] start_y;
      logic signed [COORD_W-1:0] end_x;
      logic signed [COORD_W-1:0] end_y;
   } req_item_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel_x;
      logic [PIXEL_W-1:0] pixel_y;
      logic               last_pixel;
   } rsp_item_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ORDER,
      ST_PREP,
      ST_DIVIDE,
      ST_SLOPE,
      ST_MULT,
      ST_SEED,
      ST_WALK,
      ST_FLUSH
   } ctrl_state_type;

   typedef struct packed {
      logic load;
      logic order;
      logic prep;
      logic div_step;
      logic slope;
      logic mult;
      logic seed;
      logic walk;
      logic flush;
   } dlpg_cmd_type;

   typedef struct packed {
      logic div_last;
      logic walk_empty;
      logic walk_last;
   } dlpg_status_type;

endpackage

@@ rtl/dlpg_datapath.sv @@
// Datapath: endpoint ordering, serial slope divider, seed multiply and pixel walk.
module dlpg_datapath #(
   parameter int SLOPE_FRACTION_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  dlpg_pkg::dlpg_cmd_type         cmd,
   output dlpg_pkg::dlpg_status_type      status,
   input  dlpg_pkg::req_item_type         req_item,
   input  logic [dlpg_pkg::EXTENT_W-1:0]  width_limit,
   input  logic [dlpg_pkg::EXTENT_W-1:0]  height_limit,
   output logic                           rsp_valid,
   output dlpg_pkg::rsp_item_type         rsp_item
);
   import dlpg_pkg::*;

   localparam int F = SLOPE_FRACTION_BITS;
   localparam int WIDE_W = COORD_W + 1;
   localparam int SLOPE_W = F + 2;
   localparam int DVD_W = COORD_W + F;
   localparam int CNT_W = $clog2(DVD_W);
   localparam int ACC_W = COORD_W + F + 3;
   localparam int MINOR_W = ACC_W - F;

   req_item_type               item_ff, item_in;
   logic signed [COORD_W-1:0]  a0_ff, a0_in, a1_ff, a1_in, b0_ff, b0_in, b1_ff, b1_in;
   logic [EXTENT_W-1:0]        lim_major_ff, lim_major_in, lim_minor_ff, lim_minor_in;
   logic                       y_major_ff, y_major_in;
   logic                       db_neg_ff, db_neg_in;
   logic [COORD_W-1:0]         da_ff, da_in;
   logic                       walk_empty_ff, walk_empty_in;
   logic [EXTENT_W-1:0]        m_ff, m_in, end_ff, end_in;
   logic [COORD_W-1:0]         offset_ff, offset_in;
   logic [COORD_W-1:0]         rem_ff, rem_in;
   logic [DVD_W-1:0]           quot_ff, quot_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic signed [SLOPE_W-1:0]  slope_ff, slope_in;
   logic signed [ACC_W-1:0]    product_ff, product_in;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic                       pend_valid_ff, pend_valid_in;
   rsp_item_type               pend_ff, pend_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   rsp_item_type               rsp_ff, rsp_in;

   logic signed [WIDE_W-1:0]   dx, dy, ax, ay;
   logic                       y_major_calc, swap;
   logic signed [COORD_W-1:0]  pa0, pa1, pb0, pb1;
   logic [EXTENT_W-1:0]        w_clamped, h_clamped;
   logic signed [WIDE_W-1:0]   da_wide, db_wide, adb_wide, start_wide, end_wide;
   logic signed [WIDE_W-1:0]   a0_wide, a1_wide, lim_wide, offset_wide;
   logic [WIDE_W-1:0]          rem_shift;
   logic                       fits;
   logic [WIDE_W-1:0]          rem_diff;
   logic signed [SLOPE_W-1:0]  quot_signed;
   logic signed [ACC_W-1:0]    b0_scaled, slope_ext;
   logic [MINOR_W-1:0]         minor;
   logic                       visible;
   rsp_item_type               cur_pixel;

   always_comb begin
      dx = $signed({item_ff.end_x[COORD_W-1], item_ff.end_x})
         - $signed({item_ff.start_x[COORD_W-1], item_ff.start_x});
      dy = $signed({item_ff.end_y[COORD_W-1], item_ff.end_y})
         - $signed({item_ff.start_y[COORD_W-1], item_ff.start_y});
      ax = dx[WIDE_W-1] ? -dx : dx;
      ay = dy[WIDE_W-1] ? -dy : dy;
      y_major_calc = !($unsigned(ax) > $unsigned(ay));
      pa0 = y_major_calc ? item_ff.start_y : item_ff.start_x;
      pa1 = y_major_calc ? item_ff.end_y : item_ff.end_x;
      pb0 = y_major_calc ? item_ff.start_x : item_ff.start_y;
      pb1 = y_major_calc ? item_ff.end_x : item_ff.end_y;
      swap = pa0 > pa1;
      w_clamped = (width_limit > MAX_WIDTH) ? MAX_WIDTH : width_limit;
      h_clamped = (height_limit > MAX_HEIGHT) ? MAX_HEIGHT : height_limit;

      a0_wide = $signed({a0_ff[COORD_W-1], a0_ff});
      a1_wide = $signed({a1_ff[COORD_W-1], a1_ff});
      da_wide = a1_wide - a0_wide;
      db_wide = $signed({b1_ff[COORD_W-1], b1_ff}) - $signed({b0_ff[COORD_W-1], b0_ff});
      adb_wide = db_wide[WIDE_W-1] ? -db_wide : db_wide;
      lim_wide = $signed({{(WIDE_W-EXTENT_W){1'b0}}, lim_major_ff});
      start_wide = a0_ff[COORD_W-1] ? '0 : a0_wide;
      end_wide = (a1_wide < lim_wide) ? a1_wide : lim_wide;
      offset_wide = start_wide - a0_wide;

      rem_shift = {rem_ff, quot_ff[DVD_W-1]};
      fits = rem_shift >= {1'b0, da_ff};
      rem_diff = rem_shift - {1'b0, da_ff};

      quot_signed = $signed({1'b0, quot_ff[SLOPE_W-2:0]});
      b0_scaled = $signed({{(ACC_W-COORD_W-F){b0_ff[COORD_W-1]}}, b0_ff, {F{1'b0}}});
      slope_ext = $signed({{(ACC_W-SLOPE_W){slope_ff[SLOPE_W-1]}}, slope_ff});

      minor = acc_ff[ACC_W-1:F];
      visible = !acc_ff[ACC_W-1] && (m_ff != '0) && (m_ff < lim_major_ff)
         && (minor != '0) && (minor < {{(MINOR_W-EXTENT_W){1'b0}}, lim_minor_ff});
      cur_pixel.pixel_x = y_major_ff ? minor[PIXEL_W-1:0] : m_ff[PIXEL_W-1:0];
      cur_pixel.pixel_y = y_major_ff ? m_ff[PIXEL_W-1:0] : minor[PIXEL_W-1:0];
      cur_pixel.last_pixel = 1'b0;
   end

   always_comb begin
      item_in = item_ff;
      a0_in = a0_ff;
      a1_in = a1_ff;
      b0_in = b0_ff;
      b1_in = b1_ff;
      lim_major_in = lim_major_ff;
      lim_minor_in = lim_minor_ff;
      y_major_in = y_major_ff;
      db_neg_in = db_neg_ff;
      da_in = da_ff;
      walk_empty_in = walk_empty_ff;
      m_in = m_ff;
      end_in = end_ff;
      offset_in = offset_ff;
      rem_in = rem_ff;
      quot_in = quot_ff;
      cnt_in = cnt_ff;
      slope_in = slope_ff;
      product_in = product_ff;
      acc_in = acc_ff;
      pend_valid_in = pend_valid_ff;
      pend_in = pend_ff;
      rsp_valid_in = 1'b0;
      rsp_in = rsp_ff;

      if (cmd.load) begin
         item_in = req_item;
      end
      if (cmd.order) begin
         y_major_in = y_major_calc;
         a0_in = swap ? pa1 : pa0;
         a1_in = swap ? pa0 : pa1;
         b0_in = swap ? pb1 : pb0;
         b1_in = swap ? pb0 : pb1;
         lim_major_in = y_major_calc ? h_clamped : w_clamped;
         lim_minor_in = y_major_calc ? w_clamped : h_clamped;
      end
      if (cmd.prep) begin
         da_in = da_wide[COORD_W-1:0];
         db_neg_in = db_wide[WIDE_W-1];
         walk_empty_in = start_wide > end_wide;
         m_in = start_wide[EXTENT_W-1:0];
         end_in = end_wide[EXTENT_W-1:0];
         offset_in = offset_wide[COORD_W-1:0];
         rem_in = '0;
         quot_in = {adb_wide[COORD_W-1:0], {F{1'b0}}};
         cnt_in = '0;
      end
      if (cmd.div_step) begin
         rem_in = fits ? rem_diff[COORD_W-1:0] : rem_shift[COORD_W-1:0];
         quot_in = {quot_ff[DVD_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
      end
      if (cmd.slope) begin
         if (da_ff == '0) begin
            slope_in = '0;
         end else begin
            slope_in = db_neg_ff ? -quot_signed : quot_signed;
         end
      end
      if (cmd.mult) begin
         product_in = ACC_W'(slope_ff) * ACC_W'($signed({1'b0, offset_ff}));
      end
      if (cmd.seed) begin
         acc_in = b0_scaled + product_ff;
      end
      if (cmd.walk) begin
         acc_in = acc_ff + slope_ext;
         m_in = m_ff + 1'b1;
         if (visible) begin
            if (pend_valid_ff) begin
               rsp_valid_in = 1'b1;
               rsp_in = pend_ff;
            end
            pend_valid_in = 1'b1;
            pend_in = cur_pixel;
         end
      end
      if (cmd.flush) begin
         if (pend_valid_ff) begin
            rsp_valid_in = 1'b1;
            rsp_in = pend_ff;
            rsp_in.last_pixel = 1'b1;
         end
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff <= item_in;
      a0_ff <= a0_in;
      a1_ff <= a1_in;
      b0_ff <= b0_in;
      b1_ff <= b1_in;
      lim_major_ff <= lim_major_in;
      lim_minor_ff <= lim_minor_in;
      y_major_ff <= y_major_in;
      db_neg_ff <= db_neg_in;
      da_ff <= da_in;
      walk_empty_ff <= walk_empty_in;
      m_ff <= m_in;
      end_ff <= end_in;
      offset_ff <= offset_in;
      rem_ff <= rem_in;
      quot_ff <= quot_in;
      cnt_ff <= cnt_in;
      slope_ff <= slope_in;
      product_ff <= product_in;
      acc_ff <= acc_in;
      pend_ff <= pend_in;
      rsp_ff <= rsp_in;
   end

   assign status.div_last = cnt_ff == CNT_W'(DVD_W - 1);
   assign status.walk_empty = walk_empty_ff;
   assign status.walk_last = m_ff == end_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item = rsp_ff;

endmodule

@@ rtl/dlpg_ctrl.sv @@
// Controller state machine that sequences one line through the datapath.
module dlpg_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   output dlpg_pkg::dlpg_cmd_type     cmd,
   input  dlpg_pkg::dlpg_status_type  status
);
   import dlpg_pkg::*;

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_ORDER;
            end
         end
         ST_ORDER: begin
            cmd.order = 1'b1;
            state_in = ST_PREP;
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_SLOPE;
            end
         end
         ST_SLOPE: begin
            cmd.slope = 1'b1;
            state_in = ST_MULT;
         end
         ST_MULT: begin
            cmd.mult = 1'b1;
            state_in = ST_SEED;
         end
         ST_SEED: begin
            cmd.seed = 1'b1;
            state_in = status.walk_empty ? ST_FLUSH : ST_WALK;
         end
         ST_WALK: begin
            cmd.walk = 1'b1;
            if (status.walk_last) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            cmd.flush = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = state_ff != ST_IDLE;

endmodule

@@ rtl/dda_line_pixel_generator_core.sv @@
// Top level of the DDA line pixel generator: extent registers, controller and datapath.
//
//   channel   ports                                   handshake
//   request   start, busy, req_item                   taken when start && !busy
//   result    rsp_valid, rsp_item                     one cycle per item, no backpressure
//   config    csr_write_enable, csr_index, csr_data   written on any enabled edge
//
// A line keeps busy high through the order, prep, serial slope divider, slope, multiply
// and seed states, a pixel walk over the n major-axis steps left after clipping to 0 through
// the extent (0 to 65) at one step per cycle, and a closing flush. Each result item
// is held until the next visible step or the closing flush, so the last item shows in the
// first idle cycle. Synchronous reset returns the block to idle with both extents at 64.
// The receiver cannot stall results.
module dda_line_pixel_generator_core #(
   parameter int SLOPE_FRACTION_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  dlpg_pkg::req_item_type            req_item,
   output logic                              rsp_valid,
   output dlpg_pkg::rsp_item_type            rsp_item,
   input  logic                              csr_write_enable,
   input  logic [dlpg_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [dlpg_pkg::CSR_DATA_W-1:0]   csr_data
);
   import dlpg_pkg::*;

   logic [EXTENT_W-1:0] width_ff, width_in, height_ff, height_in;
   dlpg_cmd_type        cmd;
   dlpg_status_type     status;

   always_comb begin
      width_in = width_ff;
      height_in = height_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_ACTIVE_WIDTH:  width_in = csr_data;
            CSR_ACTIVE_HEIGHT: height_in = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= EXTENT_RESET;
         height_ff <= EXTENT_RESET;
      end else begin
         width_ff <= width_in;
         height_ff <= height_in;
      end
   end

   dlpg_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .cmd    (cmd),
      .status (status)
   );

   dlpg_datapath #(
      .SLOPE_FRACTION_BITS (SLOPE_FRACTION_BITS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_item     (req_item),
      .width_limit  (width_ff),
      .height_limit (height_ff),
      .rsp_valid    (rsp_valid),
      .rsp_item     (rsp_item)
   );

   // Accepting an item always starts a busy period.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted item did not raise busy");

   // The flagged item closes a line, so nothing follows it directly.
   a_last_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.last_pixel |=> !rsp_valid)
      else $error("result item directly after the last pixel");

   // While idle, only the closing item of the previous line may still show.
   a_idle_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !busy |-> rsp_item.last_pixel)
      else $error("unflagged result item while idle");

   // Result items come only from a line in progress or just finished.
   a_rsp_in_line: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy || $past(busy))
      else $error("result item outside a line");

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the DDA line pixel generator: directed lines, then random lines.
`timescale 1ns / 1ps

module tb_top;
   import dlpg_pkg::*;

   localparam int FRAC_BITS = 16;
   localparam int STALL_LIMIT = 4000;
   localparam int RANDOM_LINES_PER_MODE = 36;

   typedef struct {
      bit                     is_write;
      logic [CSR_INDEX_W-1:0] csr_idx;
      logic [CSR_DATA_W-1:0]  csr_val;
      req_item_type           line;
      bit                     fixed;
      int                     fixed_count;
      rsp_item_type           fixed_pixel;
   } plan_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   req_item_type           req_item = '0;
   logic                   rsp_valid;
   rsp_item_type           rsp_item;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   logic [EXTENT_W-1:0] surface_width = EXTENT_RESET;
   logic [EXTENT_W-1:0] surface_height = EXTENT_RESET;
   rsp_item_type        expected_pixels[$];
   plan_row_type        directed_plan[$];

   bit           use_fixed_pixels = 1'b0;
   int           fixed_count = 0;
   rsp_item_type fixed_pixel = '0;

   int sender_idle_pct = 34;
   int error_count = 0;
   int lines_taken = 0;
   int pixels_checked = 0;
   int extent_writes = 0;
   int quiet_cycles = 0;

   dda_line_pixel_generator_core #(
      .SLOPE_FRACTION_BITS(FRAC_BITS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_item(req_item),
      .rsp_valid(rsp_valid),
      .rsp_item(rsp_item),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #6 clock = ~clock;

   function automatic void predict_line_pixels(input req_item_type line);
      longint sx, sy, ex, ey, a0, a1, b0, b1, swap, da, db, adx, ady;
      longint slope, total, minor, m, first_m, last_m, w, h, lim_major, lim_minor;
      bit y_major;
      int count;
      rsp_item_type pix;
      sx = $signed(line.start_x);
      sy = $signed(line.start_y);
      ex = $signed(line.end_x);
      ey = $signed(line.end_y);
      w = (surface_width > MAX_WIDTH) ? longint'(MAX_WIDTH) : longint'(surface_width);
      h = (surface_height > MAX_HEIGHT) ? longint'(MAX_HEIGHT) : longint'(surface_height);
      adx = (ex < sx) ? sx - ex : ex - sx;
      ady = (ey < sy) ? sy - ey : ey - sy;
      y_major = !(adx > ady);
      if (!y_major) begin
         a0 = sx; a1 = ex; b0 = sy; b1 = ey; lim_major = w; lim_minor = h;
      end else begin
         a0 = sy; a1 = ey; b0 = sx; b1 = ex; lim_major = h; lim_minor = w;
      end
      if (a0 > a1) begin
         swap = a0; a0 = a1; a1 = swap;
         swap = b0; b0 = b1; b1 = swap;
      end
      da = a1 - a0;
      db = b1 - b0;
      slope = (da != 0) ? (db * (longint'(1) <<< FRAC_BITS)) / da : 0;
      first_m = (a0 < 0) ? 0 : a0;
      last_m = (a1 < lim_major) ? a1 : lim_major;
      count = 0;
      for (m = first_m; m <= last_m; m++) begin
         total = b0 * (longint'(1) <<< FRAC_BITS) + slope * (m - a0);
         if (total >= 0) begin
            minor = total >>> FRAC_BITS;
            if (m > 0 && m < lim_major && minor > 0 && minor < lim_minor) begin
               pix.pixel_x = y_major ? minor[PIXEL_W-1:0] : m[PIXEL_W-1:0];
               pix.pixel_y = y_major ? m[PIXEL_W-1:0] : minor[PIXEL_W-1:0];
               pix.last_pixel = 1'b0;
               expected_pixels.push_back(pix);
               count++;
            end
         end
      end
      if (count > 0) expected_pixels[expected_pixels.size()-1].last_pixel = 1'b1;
   endfunction

   // Expectations are queued on the accepting edge; results are checked in the same process.
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (rsp_valid) begin
            if (expected_pixels.size() == 0) begin
               if (error_count < 10)
                  $display("%0t: unexpected pixel x=%0d y=%0d last=%0b", $realtime,
                           rsp_item.pixel_x, rsp_item.pixel_y, rsp_item.last_pixel);
               error_count++;
            end else begin
               if (rsp_item.pixel_x !== expected_pixels[0].pixel_x ||
                   rsp_item.pixel_y !== expected_pixels[0].pixel_y ||
                   rsp_item.last_pixel !== expected_pixels[0].last_pixel) begin
                  if (error_count < 10)
                     $display("%0t: expected x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
                              $realtime, expected_pixels[0].pixel_x, expected_pixels[0].pixel_y,
                              expected_pixels[0].last_pixel, rsp_item.pixel_x, rsp_item.pixel_y,
                              rsp_item.last_pixel);
                  error_count++;
               end
               void'(expected_pixels.pop_front());
               pixels_checked++;
            end
         end
         if (start && !busy) begin
            lines_taken++;
            if (use_fixed_pixels) begin
               if (fixed_count > 0) expected_pixels.push_back(fixed_pixel);
            end else begin
               predict_line_pixels(req_item);
            end
         end
         if ((start && !busy) || rsp_valid) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Timeout: no activity for %0d cycles", STALL_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   function automatic plan_row_type row_write(input logic [CSR_INDEX_W-1:0] idx,
                                              input int val);
      plan_row_type row;
      row = '{default: '0};
      row.is_write = 1'b1;
      row.csr_idx = idx;
      row.csr_val = val[CSR_DATA_W-1:0];
      return row;
   endfunction

   function automatic plan_row_type row_line(input int sx, input int sy, input int ex,
                                             input int ey);
      plan_row_type row;
      row = '{default: '0};
      row.line.start_x = sx[COORD_W-1:0];
      row.line.start_y = sy[COORD_W-1:0];
      row.line.end_x = ex[COORD_W-1:0];
      row.line.end_y = ey[COORD_W-1:0];
      return row;
   endfunction

   function automatic plan_row_type row_fixed(input int sx, input int sy, input int ex,
                                              input int ey, input int count, input int px,
                                              input int py);
      plan_row_type row;
      row = row_line(sx, sy, ex, ey);
      row.fixed = 1'b1;
      row.fixed_count = count;
      row.fixed_pixel.pixel_x = px[PIXEL_W-1:0];
      row.fixed_pixel.pixel_y = py[PIXEL_W-1:0];
      row.fixed_pixel.last_pixel = 1'b1;
      return row;
   endfunction

   function automatic logic [COORD_W-1:0] near_coord();
      int v;
      v = int'($urandom_range(90)) - 10;
      return v[COORD_W-1:0];
   endfunction

   function automatic req_item_type random_line();
      req_item_type line;
      int kind;
      logic [63:0] raw;
      kind = $urandom_range(99);
      line.start_x = near_coord();
      line.start_y = near_coord();
      line.end_x = near_coord();
      line.end_y = near_coord();
      if (kind >= 80) begin
         raw = {$urandom, $urandom};
         line = raw[$bits(req_item_type)-1:0];
      end else if (kind >= 70) begin
         if ($urandom_range(1)) line.end_x = line.start_x;
         else line.end_y = line.start_y;
      end else if (kind >= 60) begin
         line.end_x = line.start_x;
         line.end_y = line.start_y;
      end
      return line;
   endfunction

   function automatic int pick_extent();
      case ($urandom_range(9))
         0: return 0;
         1: return 1;
         2: return 65 + $urandom_range(62);
         3, 4: return int'(MAX_WIDTH);
         default: return $urandom_range(2, 63);
      endcase
   endfunction

   task automatic send_line(input req_item_type line);
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      req_item <= line;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   task automatic write_extent(input logic [CSR_INDEX_W-1:0] idx, input int val);
      @(negedge clock);
      start <= 1'b0;
      while (expected_pixels.size() != 0 || busy) @(negedge clock);
      repeat (3) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_data <= val[CSR_DATA_W-1:0];
      if (idx == CSR_ACTIVE_WIDTH) surface_width = val[CSR_DATA_W-1:0];
      else surface_height = val[CSR_DATA_W-1:0];
      extent_writes++;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      int mode, k;
      directed_plan = '{
         row_write(CSR_ACTIVE_WIDTH, 64),
         row_write(CSR_ACTIVE_HEIGHT, 64),
         row_fixed(5, 7, 5, 7, 1, 5, 7),
         row_fixed(0, 0, 0, 0, 0, 0, 0),
         row_fixed(63, 63, 63, 63, 1, 63, 63),
         row_fixed(64, 10, 64, 10, 0, 0, 0),
         row_fixed(1, 1, 1, 1, 1, 1, 1),
         row_fixed(-2048, -2048, -1000, -1500, 0, 0, 0),
         row_fixed(2047, 2047, 2047, 2047, 0, 0, 0),
         row_line(-2048, 2047, 2047, -2048),
         row_line(2047, -2048, -2048, 2047),
         row_line(1, 5, 62, 5),
         row_line(62, 40, 3, 40),
         row_line(9, 1, 9, 63),
         row_line(0, 0, 63, 63),
         row_line(2, 60, 61, 3),
         row_line(10, 2, 30, 61),
         row_line(-30, -5, 90, 70),
         row_line(50, -100, 20, 200),
         row_write(CSR_ACTIVE_WIDTH, 127),
         row_write(CSR_ACTIVE_HEIGHT, 127),
         row_line(-5, 30, 100, 34),
         row_write(CSR_ACTIVE_WIDTH, 0),
         row_fixed(5, 5, 5, 5, 0, 0, 0),
         row_write(CSR_ACTIVE_WIDTH, 1),
         row_write(CSR_ACTIVE_HEIGHT, 1),
         row_line(0, 0, 63, 63),
         row_write(CSR_ACTIVE_WIDTH, 13),
         row_write(CSR_ACTIVE_HEIGHT, 40),
         row_line(-3, -3, 50, 50),
         row_line(12, 1, 1, 39)
      };

      repeat (10) @(negedge clock);
      reset <= 1'b0;

      foreach (directed_plan[i]) begin
         if (directed_plan[i].is_write) begin
            write_extent(directed_plan[i].csr_idx, int'(directed_plan[i].csr_val));
         end else begin
            use_fixed_pixels = directed_plan[i].fixed;
            fixed_count = directed_plan[i].fixed_count;
            fixed_pixel = directed_plan[i].fixed_pixel;
            send_line(directed_plan[i].line);
         end
      end
      use_fixed_pixels = 1'b0;

      for (mode = 0; mode < 3; mode++) begin
         sender_idle_pct = (mode == 0) ? 34 : (mode == 1) ? 86 : 0;
         for (k = 0; k < RANDOM_LINES_PER_MODE; k++) begin
            if (k % 11 == 0) begin
               write_extent(CSR_ACTIVE_WIDTH, pick_extent());
               write_extent(CSR_ACTIVE_HEIGHT, pick_extent());
            end
            send_line(random_line());
         end
      end

      @(negedge clock);
      start <= 1'b0;
      while (expected_pixels.size() != 0 || busy) @(negedge clock);
      repeat (8) @(negedge clock);
      if (expected_pixels.size() != 0) error_count++;

      $display("Drew %0d lines and checked %0d pixels over %0d extent register writes,",
               lines_taken, pixels_checked, extent_writes);
      $display("with the sender idling sometimes, mostly and never; %0d mismatches.",
               error_count);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
